FILE: src/i2a_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and character tables for the integer to ascii converter
package i2a_pkg;

    localparam int INT_WIDTH      = 32;
    localparam int POINTER_DIGITS = 16;
    localparam int PTR_BITS       = POINTER_DIGITS * 4;
    localparam int WORK_W         = (PTR_BITS > INT_WIDTH) ? PTR_BITS : INT_WIDTH;
    localparam int VALUE_W        = 64;
    localparam int ACTION_W       = 3;
    localparam int CHAR_W         = 8;
    localparam int DIGIT_W        = 4;
    localparam int DIGIT_SLOTS    = 16;
    localparam int SLOT_W         = $clog2(DIGIT_SLOTS);
    localparam int CNT_W          = 5;

    // reciprocal of ten, exact for any operand below 2^32
    localparam int                RECIP_W     = 32;
    localparam logic [RECIP_W-1:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam int                RECIP_SHIFT = 35;
    localparam int                PROD_W      = INT_WIDTH + RECIP_W;
    localparam int                Q10_W       = PROD_W - RECIP_SHIFT;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_X     = 8'h78;

    localparam logic [CHAR_W-1:0] UPPER_DIGITS [DIGIT_SLOTS] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };
    localparam logic [CHAR_W-1:0] LOWER_DIGITS [DIGIT_SLOTS] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [ACTION_W-1:0] {
        ACT_SDEC = 3'd0,
        ACT_OCT  = 3'd1,
        ACT_UDEC = 3'd2,
        ACT_HEX  = 3'd3,
        ACT_PTR  = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        BASE_8,
        BASE_10,
        BASE_16
    } t_base;

    typedef enum logic [1:0] {
        PRE_NONE,
        PRE_MINUS,
        PRE_HEX
    } t_prefix;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SPLIT,
        S_PRE,
        S_PREX,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_base base;
        logic  mul_en;
    } t_unit_ctl;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                     input logic lower);
        return lower ? LOWER_DIGITS[d] : UPPER_DIGITS[d];
    endfunction

endpackage

FILE: src/integer_to_ascii_radix_converter.sv
`timescale 1ns / 1ps
// top level of the integer to ascii radix converter
// sequence: octal, hex and pointer split each digit in S_SPLIT, decimal first goes
//   through S_MUL (registered divide-by-ten product); then one character per cycle
//   while the output is free; a new transaction is taken only back in S_IDLE, once
//   the last character has entered the output register, so output stalls delay it
// reset: synchronous active-low i_rst_n idles the sequencer and empties the output register
module integer_to_ascii_radix_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // [63:0] value
    input  logic [2:0]  s_axis_tuser,  // [2:0] action
    // output side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_char
    output logic        m_axis_tlast   // last_char
);
    import i2a_pkg::*;

    t_unit_ctl          unit_ctl;
    logic [WORK_W-1:0]  work;
    logic [WORK_W-1:0]  quot;
    logic [DIGIT_W-1:0] rem;

    // sequencer: takes the transaction, drives the digit unit, then emits prefix and digits
    i2a_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_action   (s_axis_tuser),
        .i_value    (s_axis_tdata),
        .o_m_valid  (m_axis_tvalid),
        .i_m_ready  (m_axis_tready),
        .o_m_char   (m_axis_tdata),
        .o_m_last   (m_axis_tlast),
        .o_unit_ctl (unit_ctl),
        .o_work     (work),
        .i_quot     (quot),
        .i_rem      (rem)
    );

    // shared divide unit, one digit per use
    i2a_digit_unit u_digit (
        .i_clk  (i_clk),
        .i_ctl  (unit_ctl),
        .i_work (work),
        .o_quot (quot),
        .o_rem  (rem)
    );

endmodule

FILE: src/i2a_digit_unit.sv
`timescale 1ns / 1ps
// shared digit unit: splits the low digit off the working value for base 8, 10 or 16
module i2a_digit_unit (
    input  logic                      i_clk,
    input  i2a_pkg::t_unit_ctl        i_ctl,
    input  logic [i2a_pkg::WORK_W-1:0] i_work,
    output logic [i2a_pkg::WORK_W-1:0] o_quot,
    output logic [i2a_pkg::DIGIT_W-1:0] o_rem
);
    import i2a_pkg::*;

    logic [PROD_W-1:0]  r_prod;
    logic [Q10_W-1:0]   q10;
    logic [DIGIT_W-1:0] q_lo;
    logic [DIGIT_W-1:0] q_times_ten;

    // reciprocal product, registered before the quotient is used
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(i_work[INT_WIDTH-1:0]) * PROD_W'(RECIP_10);
        end
    end

    assign q10  = r_prod[PROD_W-1:RECIP_SHIFT];
    assign q_lo = q10[DIGIT_W-1:0];
    // low nibble of q*10 is all the remainder needs
    assign q_times_ten = {q_lo[0], 3'b000} + {q_lo[2:0], 1'b0};

    always_comb begin
        case (i_ctl.base)
            BASE_8: begin
                o_quot = i_work >> 3;
                o_rem  = {1'b0, i_work[2:0]};
            end
            BASE_10: begin
                o_quot = WORK_W'(q10);
                o_rem  = i_work[DIGIT_W-1:0] - q_times_ten;
            end
            BASE_16: begin
                o_quot = i_work >> 4;
                o_rem  = i_work[DIGIT_W-1:0];
            end
            default: begin
                o_quot = '0;
                o_rem  = '0;
            end
        endcase
    end

endmodule

FILE: src/i2a_ctrl.sv
`timescale 1ns / 1ps
// sequencer, digit store and output register of the integer to ascii converter
module i2a_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_valid,
    output logic                         o_s_ready,
    input  logic [i2a_pkg::ACTION_W-1:0] i_action,
    input  logic [i2a_pkg::VALUE_W-1:0]  i_value,
    output logic                         o_m_valid,
    input  logic                         i_m_ready,
    output logic [i2a_pkg::CHAR_W-1:0]   o_m_char,
    output logic                         o_m_last,
    output i2a_pkg::t_unit_ctl           o_unit_ctl,
    output logic [i2a_pkg::WORK_W-1:0]   o_work,
    input  logic [i2a_pkg::WORK_W-1:0]   i_quot,
    input  logic [i2a_pkg::DIGIT_W-1:0]  i_rem
);
    import i2a_pkg::*;

    t_state              r_state, n_state;
    logic [WORK_W-1:0]   r_work;
    t_base               r_base;
    logic                r_lower;
    t_prefix             r_pre;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIGIT_W-1:0]  r_store [DIGIT_SLOTS];
    logic                r_ovalid;
    logic [CHAR_W-1:0]   r_char;
    logic                r_last;

    logic                accept, act_ok, is_dec, out_free, emit, step, split_done;
    logic                neg;
    logic [INT_WIDTH-1:0] word, mag;
    logic [WORK_W-1:0]   load_work;
    t_base               load_base;
    t_prefix             load_pre;
    logic [CHAR_W-1:0]   emit_char;
    logic                emit_last;
    logic [SLOT_W-1:0]   rd_slot;

    // input decode
    always_comb begin
        act_ok = (i_action <= ACTION_W'(ACT_PTR));
        is_dec = (i_action == ACT_SDEC) || (i_action == ACT_UDEC);
        word   = i_value[INT_WIDTH-1:0];
        neg    = (i_action == ACT_SDEC) && word[INT_WIDTH-1];
        mag    = neg ? (~word + 1'b1) : word;
        case (i_action)
            ACT_SDEC, ACT_UDEC: load_base = BASE_10;
            ACT_OCT:            load_base = BASE_8;
            default:            load_base = BASE_16;
        endcase
        if (i_action == ACT_PTR) begin
            load_work = WORK_W'(i_value[PTR_BITS-1:0]);
            load_pre  = PRE_HEX;
        end else begin
            load_work = WORK_W'(mag);
            load_pre  = neg ? PRE_MINUS : PRE_NONE;
        end
    end

    assign out_free   = !r_ovalid || i_m_ready;
    assign split_done = (i_quot == '0) || (r_cnt == CNT_W'(DIGIT_SLOTS - 1));
    assign rd_slot    = SLOT_W'(r_cnt - 1'b1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_valid && act_ok) begin
                    n_state = is_dec ? S_MUL : S_SPLIT;
                end
            end
            S_MUL:   n_state = S_SPLIT;
            S_SPLIT: begin
                if (split_done) begin
                    n_state = (r_pre == PRE_NONE) ? S_EMIT : S_PRE;
                end else begin
                    n_state = (r_base == BASE_10) ? S_MUL : S_SPLIT;
                end
            end
            S_PRE: begin
                if (out_free) begin
                    n_state = (r_pre == PRE_HEX) ? S_PREX : S_EMIT;
                end
            end
            S_PREX: begin
                if (out_free) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free && r_cnt == CNT_W'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_ready         = (r_state == S_IDLE);
        accept            = o_s_ready && i_s_valid;
        step              = (r_state == S_SPLIT);
        o_unit_ctl.base   = r_base;
        o_unit_ctl.mul_en = (r_state == S_MUL);
        emit              = (r_state inside {S_PRE, S_PREX, S_EMIT}) && out_free;
        emit_last         = 1'b0;
        case (r_state)
            S_PRE:  emit_char = (r_pre == PRE_HEX) ? CH_ZERO : CH_MINUS;
            S_PREX: emit_char = CH_X;
            S_EMIT: begin
                emit_char = digit_char(r_store[rd_slot], r_lower);
                emit_last = (r_cnt == CNT_W'(1));
            end
            default: emit_char = CH_ZERO;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (step) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (emit && r_state == S_EMIT) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && act_ok) begin
            r_work  <= load_work;
            r_base  <= load_base;
            r_lower <= (i_action == ACT_PTR);
            r_pre   <= load_pre;
        end else if (step) begin
            r_work <= i_quot;
        end
        if (step) begin
            r_store[r_cnt[SLOT_W-1:0]] <= i_rem;
        end
        if (emit) begin
            r_char <= emit_char;
            r_last <= emit_last;
        end
    end

    assign o_work    = r_work;
    assign o_m_valid = r_ovalid;
    assign o_m_char  = r_char;
    assign o_m_last  = r_last;

endmodule

FILE: src/i2a_checker.sv
`timescale 1ns / 1ps
// port-level checks of the integer to ascii converter and their bind
module i2a_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);
    import i2a_pkg::*;

    // a stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // a valid conversion keeps the input side closed while it runs
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser <= ACT_PTR) |=> !s_axis_tready)
        else $error("input accepted while a conversion runs");

    // an unused action is dropped and the input stays open
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser > ACT_PTR) |=> s_axis_tready)
        else $error("unused action stalled the input");

    // every character lies between '-' and 'x'
    a_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >= CH_MINUS) && (m_axis_tdata <= CH_X))
        else $error("character out of range");

endmodule

bind integer_to_ascii_radix_converter i2a_checker u_i2a_checker (.*);

FILE: tb/sv/tb_integer_to_ascii_radix_converter.sv
`timescale 1ns / 1ps
// self-checking testbench for the integer to ascii radix converter
module tb_integer_to_ascii_radix_converter;
    import i2a_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    // settle time after the last expected character, longer than a ten-digit decimal
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS  = 24;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_expected_char;

    // predicts the text of each accepted number and checks characters in order
    class i2a_scoreboard;
        t_expected_char expected_chars[$];
        int mismatches;
        int conversions;
        int ignored;

        function void push_char(logic [CHAR_W-1:0] ch, logic last);
            t_expected_char e;
            e.ch   = ch;
            e.last = last;
            expected_chars.push_back(e);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        // spells one accepted number into its expected characters
        function void note_number(logic [ACTION_W-1:0] action, logic [VALUE_W-1:0] value);
            logic [VALUE_W-1:0]   mag;
            logic [VALUE_W-1:0]   base;
            logic [VALUE_W-1:0]   rem;
            logic [INT_WIDTH-1:0] word;
            logic [DIGIT_W-1:0]   digits [DIGIT_SLOTS];
            logic                 lower;
            int                   n;
            if (action > ACT_PTR) begin
                ignored++;
                return;
            end
            conversions++;
            lower = 1'b0;
            word  = value[INT_WIDTH-1:0];
            mag   = {{(VALUE_W-INT_WIDTH){1'b0}}, word};
            base  = 64'd10;
            case (action)
                ACT_SDEC: begin
                    // negative values go through their magnitude, most negative included
                    if (word[INT_WIDTH-1]) begin
                        push_char(CH_MINUS, 1'b0);
                        word = ~word + 1'b1;
                        mag  = {{(VALUE_W-INT_WIDTH){1'b0}}, word};
                    end
                end
                ACT_OCT:  base = 64'd8;
                ACT_UDEC: base = 64'd10;
                ACT_HEX:  base = 64'd16;
                default: begin
                    push_char(CH_ZERO, 1'b0);
                    push_char(CH_X, 1'b0);
                    mag   = value;
                    base  = 64'd16;
                    lower = 1'b1;
                end
            endcase
            n = 0;
            do begin
                rem       = mag % base;
                digits[n] = rem[DIGIT_W-1:0];
                mag       = mag / base;
                n++;
            end while (mag != 0 && n < DIGIT_SLOTS);
            for (int i = n - 1; i >= 0; i--) begin
                if (digits[i] < 10)
                    push_char(CH_ZERO + digits[i], i == 0);
                else
                    push_char((lower ? CH_LOWER_A : CH_UPPER_A) + digits[i] - 4'd10, i == 0);
            end
        endfunction

        task check_char(logic [CHAR_W-1:0] ch, logic last);
            t_expected_char e;
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("character %h with nothing expected", ch));
                return;
            end
            e = expected_chars.pop_front();
            if (ch !== e.ch)
                report_mismatch($sformatf("character %h, expected %h", ch, e.ch));
            if (last !== e.last)
                report_mismatch($sformatf("tlast %b, expected %b", last, e.last));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata  = '0;  // [63:0] value
    logic [ACTION_W-1:0] s_axis_tuser  = '0;  // [2:0] action
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [CHAR_W-1:0]   m_axis_tdata;        // [7:0] out_char
    logic                m_axis_tlast;        // last_char

    i2a_scoreboard sb;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_checked  = 0;
    int cycles         = 0;

    integer_to_ascii_radix_converter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_integer_to_ascii_radix_converter: FAIL");
            $finish;
        end
    end

    // receiving side: check each character transaction, then choose next tready
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_char(m_axis_tdata, m_axis_tlast);
            chars_checked++;
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offers one number and returns at the edge that accepts it
    task send_number(logic [ACTION_W-1:0] action, logic [VALUE_W-1:0] value);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= action;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_number(action, value);
    endtask

    // sender holds off until every expected character has arrived
    task drain_chars();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly valid kinds with values shaped for varied digit counts, some unused kinds
    task send_random_numbers(int count);
        logic [ACTION_W-1:0] action;
        logic [VALUE_W-1:0]  value;
        int                  done;
        done = 0;
        while (done < count) begin
            if ($urandom_range(99) < 8)
                action = ACTION_W'($urandom_range(7, 5));
            else
                action = ACTION_W'($urandom_range(4, 0));
            value = {$urandom, $urandom};
            case ($urandom_range(3))
                0: ;
                1: value = value >> $urandom_range(63);
                2: value[31:0] = ~32'($urandom_range(1000));
                default: begin
                    case ($urandom_range(3))
                        0: value[31:0] = 32'h0000_0000;
                        1: value[31:0] = 32'hFFFF_FFFF;
                        2: value[31:0] = 32'h8000_0000;
                        default: value[31:0] = 32'h7FFF_FFFF;
                    endcase
                end
            endcase
            send_number(action, value);
            if (action <= ACT_PTR)
                done++;
        end
    endtask

    initial begin
        sb = new;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes of each kind, zero, most negative, unused kinds
        send_number(ACT_SDEC, 64'h0);
        send_number(ACT_SDEC, 64'h1);
        send_number(ACT_SDEC, 64'h0000_0000_FFFF_FFFF);
        send_number(ACT_SDEC, 64'h0000_0000_8000_0000);
        send_number(ACT_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
        send_number(ACT_SDEC, 64'hFFFF_FFFF_0000_007B);
        send_number(ACT_OCT,  64'h0);
        send_number(ACT_OCT,  64'hFFFF_FFFF_FFFF_FFFF);
        send_number(ACT_OCT,  64'h8);
        send_number(ACT_UDEC, 64'h0);
        send_number(ACT_UDEC, 64'h0000_0000_FFFF_FFFF);
        send_number(ACT_UDEC, 64'hDEAD_BEEF_0000_0000);
        send_number(ACT_HEX,  64'h0);
        send_number(ACT_HEX,  64'hFFFF_FFFF_FFFF_FFFF);
        send_number(ACT_HEX,  64'h1234_5678_9ABC_DEF0);
        send_number(ACT_PTR,  64'h0);
        send_number(ACT_PTR,  64'hFFFF_FFFF_FFFF_FFFF);
        send_number(ACT_PTR,  64'h8000_0000_0000_0000);
        send_number(ACT_PTR,  64'hA);
        send_number(3'd5,     64'h1234);
        send_number(3'd6,     64'hFFFF_FFFF_FFFF_FFFF);
        send_number(3'd7,     64'h0);
        drain_chars();

        send_random_numbers(PHASE_ITEMS);
        drain_chars();
        send_idle_pct  = 73;
        send_random_numbers(PHASE_ITEMS);
        drain_chars();
        send_idle_pct  = 0;
        recv_stall_pct = 73;
        send_random_numbers(PHASE_ITEMS);
        drain_chars();
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        send_random_numbers(PHASE_ITEMS);
        drain_chars();

        $display("ran %0d conversions over all five kinds plus %0d unused-kind transactions,",
                 sb.conversions, sb.ignored);
        $display("checked %0d characters under four sender/receiver idling patterns",
                 chars_checked);
        if (sb.mismatches == 0 && sb.expected_chars.size() == 0)
            $display("tb_integer_to_ascii_radix_converter: PASS");
        else
            $display("tb_integer_to_ascii_radix_converter: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
src/i2a_pkg.sv
src/i2a_digit_unit.sv
src/i2a_ctrl.sv
src/integer_to_ascii_radix_converter.sv
src/i2a_checker.sv
tb/sv/tb_integer_to_ascii_radix_converter.sv
